### rtl/arp_cache_and_responder_macros.svh
// -----------------------------------------------------------------------------
// ARP cache and responder: assertion macros
// Concurrent assertion forms for arp_cache_and_responder.sv.
// -----------------------------------------------------------------------------
`ifndef ARP_CACHE_AND_RESPONDER_MACROS_SVH
`define ARP_CACHE_AND_RESPONDER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ARP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define ARP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/arp_pkg.sv
// -----------------------------------------------------------------------------
// ARP cache and responder package
// Cache geometry, protocol codes, sequencer states and cache interface structs.
// -----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

  // Cache geometry
  localparam int CACHE_ENTRIES = 8;
  localparam int IDX_W         = $clog2(CACHE_ENTRIES);

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t LAST_IDX = idx_t'(CACHE_ENTRIES - 1);

  // Packet checks
  localparam logic [10:0] MIN_PACKET_LEN  = 11'd28;
  localparam logic [15:0] ARP_OPC_REQUEST = 16'd1;

  // Item kinds on the input side
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Opcode of the frame to send
  localparam logic [1:0] FRAME_OP_NONE    = 2'd0;
  localparam logic [1:0] FRAME_OP_REQUEST = 2'd1;
  localparam logic [1:0] FRAME_OP_REPLY   = 2'd2;

  // Result kinds
  localparam logic [1:0] RK_NONE  = 2'd0;
  localparam logic [1:0] RK_REPLY = 2'd1;
  localparam logic [1:0] RK_HIT   = 2'd2;
  localparam logic [1:0] RK_MISS  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_LOCAL_IP  = 1'b0;
  localparam logic CFG_LOCAL_MAC = 1'b1;

  localparam logic [47:0] MAC_BROADCAST = {48{1'b1}};

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_ACT
  } state_t;

  // Sequencer to cache
  typedef struct packed {
    logic        rd_en;
    idx_t        rd_idx;
    logic        wr_en;
    logic        wr_hit;
    idx_t        wr_idx;
    logic [31:0] wr_ip;
    logic [47:0] wr_mac;
    logic [31:0] key_ip;
  } cache_ctl_t;

  // Cache to sequencer
  typedef struct packed {
    logic        match;
    logic [47:0] mac;
  } cache_sts_t;

endpackage

`default_nettype wire

### rtl/arp_cache.sv
// -----------------------------------------------------------------------------
// ARP cache storage and compare unit
// IP/MAC entry memory with a registered read port, per-entry valid bits, the
// round-robin replacement pointer and the single IP comparator.
// -----------------------------------------------------------------------------
`default_nettype none

module arp_cache (
  input  wire                 clk,
  input  wire                 rst_n,
  input  arp_pkg::cache_ctl_t ctl,
  output arp_pkg::cache_sts_t sts
);

  logic [31:0] mem_ip  [arp_pkg::CACHE_ENTRIES];
  logic [47:0] mem_mac [arp_pkg::CACHE_ENTRIES];

  logic [arp_pkg::CACHE_ENTRIES-1:0] valid_r;
  logic [arp_pkg::CACHE_ENTRIES-1:0] valid_nxt;
  arp_pkg::idx_t                     next_slot_r;
  arp_pkg::idx_t                     next_slot_nxt;
  arp_pkg::idx_t                     wr_addr;

  logic [31:0] rd_ip_r;
  logic [47:0] rd_mac_r;
  logic        rd_vld_r;

  // Update the matching entry in place, else take the round-robin slot
  assign wr_addr = ctl.wr_hit ? ctl.wr_idx : next_slot_r;

  // Mark a new slot valid and advance the pointer with wrap
  always_comb begin
    valid_nxt     = valid_r;
    next_slot_nxt = next_slot_r;
    if (ctl.wr_en && !ctl.wr_hit) begin
      valid_nxt[next_slot_r] = 1'b1;
      if (next_slot_r == arp_pkg::LAST_IDX) begin
        next_slot_nxt = '0;
      end else begin
        next_slot_nxt = next_slot_r + arp_pkg::idx_t'(1);
      end
    end
  end

  // Hold valid bits, pointer and read-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      next_slot_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      next_slot_r <= next_slot_nxt;
      if (ctl.rd_en) begin
        rd_vld_r <= valid_r[ctl.rd_idx];
      end
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_ip[wr_addr]  <= ctl.wr_ip;
      mem_mac[wr_addr] <= ctl.wr_mac;
    end
    if (ctl.rd_en) begin
      rd_ip_r  <= mem_ip[ctl.rd_idx];
      rd_mac_r <= mem_mac[ctl.rd_idx];
    end
  end

  // Shared comparator on the entry just read
  assign sts.match = rd_vld_r && (rd_ip_r == ctl.key_ip);
  assign sts.mac   = rd_mac_r;

endmodule

`default_nettype wire

### rtl/arp_cache_and_responder.sv
// Sequence: a short packet goes straight from accept to loading its result; any other
//   item first scans the entries by read/compare pairs up to the first match
//   (at most CACHE_ENTRIES). A full, untaken output holds it.
// Flow: one item at a time; the next item is taken only once the sequencer is back
//   in idle after the result is loaded.
// Reset: clears valid bits, slot pointer, station IP and MAC and all handshakes.
// -----------------------------------------------------------------------------
// ARP cache and responder
// Learns sender IP/MAC pairs from received ARP packets, answers requests for
// the local IP and resolves queried IPs against the cache.
// -----------------------------------------------------------------------------
`default_nettype none
`include "arp_cache_and_responder_macros.svh"

module arp_cache_and_responder (
  input  wire          clk,
  input  wire          rst_n,
  // Input items
  input  wire          in_tvalid,
  output logic         in_tready,
  // [10:0] packet_length, [26:11] arp_operation, [74:27] snd_mac,
  // [106:75] snd_ip, [138:107] tgt_ip, [170:139] query_ip, [175:171] zero
  input  wire  [175:0] in_tdata,
  // [0] op
  input  wire          in_tuser,
  // Result items
  output logic         out_tvalid,
  input  wire          out_tready,
  // [47:0] frame_dest_mac, [49:48] frame_operation, [97:50] frame_target_mac,
  // [129:98] frame_target_ip, [177:130] resolved_mac, [183:178] zero
  output logic [183:0] out_tdata,
  // [1:0] result_kind
  output logic [1:0]   out_tuser,
  // Configuration writes
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire          cfg_index,
  input  wire  [47:0]  cfg_wdata
);

  arp_pkg::state_t     state_r;
  arp_pkg::state_t     state_nxt;
  arp_pkg::idx_t       idx_r;
  arp_pkg::idx_t       idx_nxt;
  logic                hit_r;
  logic                hit_nxt;

  arp_pkg::cache_ctl_t cache_ctl;
  arp_pkg::cache_sts_t cache_sts;

  logic                in_accept;
  logic                in_drop;
  logic                act_go;

  // Latched item fields
  logic                op_r;
  logic                drop_r;
  logic [15:0]         opc_r;
  logic [47:0]         smac_r;
  logic [31:0]         key_r;
  logic [31:0]         tip_r;

  // Station registers; the station MAC is the implied sender of every frame
  logic [31:0]         local_ip_r;
  logic [47:0]         stn_mac_r;

  // Result being formed
  logic [1:0]          res_kind;
  logic [47:0]         res_dest;
  logic [1:0]          res_fop;
  logic [47:0]         res_tmac;
  logic [31:0]         res_tip;
  logic [47:0]         res_rmac;

  // Output register
  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic [47:0]         out_dest_r;
  logic [1:0]          out_fop_r;
  logic [47:0]         out_tmac_r;
  logic [31:0]         out_tip_r;
  logic [47:0]         out_rmac_r;

  assign in_tready = (state_r == arp_pkg::ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_drop   = (in_tuser == arp_pkg::OP_PACKET) &&
                     (in_tdata[10:0] < arp_pkg::MIN_PACKET_LEN);
  assign act_go    = !out_valid_r || out_tready;

  arp_cache u_cache (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cache_ctl),
    .sts   (cache_sts)
  );

  // Next state: scan one entry per read/compare pair, stop at first match
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    case (state_r)
      arp_pkg::ST_IDLE: begin
        if (in_accept) begin
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = in_drop ? arp_pkg::ST_ACT : arp_pkg::ST_READ;
        end
      end
      arp_pkg::ST_READ: begin
        state_nxt = arp_pkg::ST_CMP;
      end
      arp_pkg::ST_CMP: begin
        if (cache_sts.match) begin
          hit_nxt   = 1'b1;
          state_nxt = arp_pkg::ST_ACT;
        end else if (idx_r == arp_pkg::LAST_IDX) begin
          state_nxt = arp_pkg::ST_ACT;
        end else begin
          idx_nxt   = idx_r + arp_pkg::idx_t'(1);
          state_nxt = arp_pkg::ST_READ;
        end
      end
      arp_pkg::ST_ACT: begin
        if (act_go) begin
          state_nxt = arp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = arp_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: cache control and the result fields
  always_comb begin
    cache_ctl.rd_en  = (state_r == arp_pkg::ST_READ);
    cache_ctl.rd_idx = idx_r;
    cache_ctl.wr_en  = (state_r == arp_pkg::ST_ACT) && act_go &&
                       (op_r == arp_pkg::OP_PACKET) && !drop_r;
    cache_ctl.wr_hit = hit_r;
    cache_ctl.wr_idx = idx_r;
    cache_ctl.wr_ip  = key_r;
    cache_ctl.wr_mac = smac_r;
    cache_ctl.key_ip = key_r;

    res_kind = arp_pkg::RK_NONE;
    res_dest = '0;
    res_fop  = arp_pkg::FRAME_OP_NONE;
    res_tmac = '0;
    res_tip  = '0;
    res_rmac = '0;
    if (op_r == arp_pkg::OP_PACKET) begin
      // Answer a request aimed at this station
      if (!drop_r && (opc_r == arp_pkg::ARP_OPC_REQUEST) && (tip_r == local_ip_r)) begin
        res_kind = arp_pkg::RK_REPLY;
        res_dest = smac_r;
        res_fop  = arp_pkg::FRAME_OP_REPLY;
        res_tmac = smac_r;
        res_tip  = key_r;
      end
    end else if (hit_r) begin
      res_kind = arp_pkg::RK_HIT;
      res_rmac = cache_sts.mac;
    end else begin
      // Miss: describe a broadcast request
      res_kind = arp_pkg::RK_MISS;
      res_dest = arp_pkg::MAC_BROADCAST;
      res_fop  = arp_pkg::FRAME_OP_REQUEST;
      res_tip  = key_r;
    end
  end

  // Sequencer control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arp_pkg::ST_IDLE;
      idx_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // Latch the item fields on accept
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_tuser;
      drop_r <= in_drop;
      opc_r  <= in_tdata[26:11];
      smac_r <= in_tdata[74:27];
      tip_r  <= in_tdata[138:107];
      key_r  <= (in_tuser == arp_pkg::OP_QUERY) ? in_tdata[170:139] : in_tdata[106:75];
    end
  end

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
      stn_mac_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        arp_pkg::CFG_LOCAL_IP:  local_ip_r <= cfg_wdata[31:0];
        arp_pkg::CFG_LOCAL_MAC: stn_mac_r  <= cfg_wdata;
        default:                local_ip_r <= local_ip_r;
      endcase
    end
  end

  // Output valid: set when a result is loaded, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == arp_pkg::ST_ACT) && act_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if ((state_r == arp_pkg::ST_ACT) && act_go) begin
      out_kind_r <= res_kind;
      out_dest_r <= res_dest;
      out_fop_r  <= res_fop;
      out_tmac_r <= res_tmac;
      out_tip_r  <= res_tip;
      out_rmac_r <= res_rmac;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'd0, out_rmac_r, out_tip_r, out_tmac_r, out_fop_r, out_dest_r};

  // Assertions
  `ARP_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_accept,
    state_r == arp_pkg::ST_READ || state_r == arp_pkg::ST_ACT,
    "accepted item did not start a scan or a drop")
  `ARP_ASSERT_NEXT(a_scan_advances, clk, rst_n,
    state_r == arp_pkg::ST_CMP && !cache_sts.match && idx_r != arp_pkg::LAST_IDX,
    state_r == arp_pkg::ST_READ && idx_r == $past(idx_r) + arp_pkg::idx_t'(1),
    "scan did not move to the next entry")
  `ARP_ASSERT_IMPL(a_none_is_empty, clk, rst_n,
    out_tvalid && out_tuser == arp_pkg::RK_NONE, out_tdata == '0,
    "empty result carries nonzero fields")
  `ARP_ASSERT_IMPL(a_hit_has_no_frame, clk, rst_n,
    out_tvalid && out_tuser == arp_pkg::RK_HIT, out_tdata[129:0] == '0,
    "lookup hit carries frame fields")

endmodule

`default_nettype wire

### tb/sv/arp_cache_and_responder_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// ARP cache and responder testbench
// Drives received ARP packets and resolve queries into the block, keeps its own
// copy of the IP-to-MAC cache to predict each result item, and compares every
// result field by field. Stimulus starts with directed items and then runs
// random phases under different station addresses. Both sides stall at random,
// and the receiver holds off once for a long stretch.
// -----------------------------------------------------------------------------

module arp_cache_and_responder_tb;

  localparam int      ITEMS_PER_PHASE = 280;
  localparam int      RAND_PHASES     = 5;
  localparam int      HOLD_CYCLES     = 300;
  localparam int      DRAIN_CYCLES    = 30;
  localparam int      POOL_SIZE       = 12;
  localparam longint  CYCLE_LIMIT     = 500000;

  typedef struct packed {
    logic        op;
    logic [10:0] len;
    logic [15:0] opc;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [31:0] tip;
    logic [31:0] qip;
  } arp_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] dest_mac;
    logic [1:0]  fop;
    logic [47:0] tmac;
    logic [31:0] tip;
    logic [47:0] rmac;
  } arp_result_t;

  // Cache predictor and store of results still due
  class arp_cache_scoreboard;
    bit          ent_valid [arp_pkg::CACHE_ENTRIES];
    bit [31:0]   ent_ip    [arp_pkg::CACHE_ENTRIES];
    bit [47:0]   ent_mac   [arp_pkg::CACHE_ENTRIES];
    int unsigned slot;
    bit [31:0]   my_ip;
    bit [47:0]   my_mac;
    arp_result_t due_results[$];
    int unsigned errors;

    function new();
      foreach (ent_valid[i]) ent_valid[i] = 1'b0;
      slot   = 0;
      my_ip  = '0;
      my_mac = '0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [47:0] val);
      if (idx == arp_pkg::CFG_LOCAL_IP) my_ip = val[31:0];
      else my_mac = val;
    endfunction

    // Return the first valid entry holding this IP, or -1
    function int find_ip(logic [31:0] ip);
      for (int i = 0; i < arp_pkg::CACHE_ENTRIES; i++)
        if (ent_valid[i] && ent_ip[i] == ip) return i;
      return -1;
    endfunction

    // Update an existing pair, or overwrite the round-robin slot
    function void learn_pair(logic [31:0] ip, logic [47:0] mac);
      int hit;
      hit = find_ip(ip);
      if (hit >= 0) begin
        ent_mac[hit] = mac;
      end else begin
        ent_valid[slot] = 1'b1;
        ent_ip[slot]    = ip;
        ent_mac[slot]   = mac;
        slot = (slot + 1) % arp_pkg::CACHE_ENTRIES;
      end
    endfunction

    function void accept_arp_item(arp_item_t it);
      arp_result_t r;
      int hit;
      r = '0;
      r.kind = arp_pkg::RK_NONE;
      r.fop  = arp_pkg::FRAME_OP_NONE;
      if (it.op == arp_pkg::OP_PACKET) begin
        if (it.len >= arp_pkg::MIN_PACKET_LEN) begin
          learn_pair(it.sip, it.smac);
          if (it.opc == arp_pkg::ARP_OPC_REQUEST && it.tip == my_ip) begin
            r.kind     = arp_pkg::RK_REPLY;
            r.dest_mac = it.smac;
            r.fop      = arp_pkg::FRAME_OP_REPLY;
            r.tmac     = it.smac;
            r.tip      = it.sip;
          end
        end
      end else begin
        hit = find_ip(it.qip);
        if (hit >= 0) begin
          r.kind = arp_pkg::RK_HIT;
          r.rmac = ent_mac[hit];
        end else begin
          r.kind     = arp_pkg::RK_MISS;
          r.dest_mac = arp_pkg::MAC_BROADCAST;
          r.fop      = arp_pkg::FRAME_OP_REQUEST;
          r.tip      = it.qip;
        end
      end
      due_results.push_back(r);
    endfunction

    function void cmp(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h, got %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_arp_result(logic [1:0] kind, logic [183:0] data);
      arp_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result kind %0d with none expected, data %h", $time, kind, data);
        errors++;
        return;
      end
      want = due_results.pop_front();
      cmp("result_kind",      64'(want.kind),     64'(kind));
      cmp("frame_dest_mac",   64'(want.dest_mac), 64'(data[47:0]));
      cmp("frame_operation",  64'(want.fop),      64'(data[49:48]));
      cmp("frame_target_mac", 64'(want.tmac),     64'(data[97:50]));
      cmp("frame_target_ip",  64'(want.tip),      64'(data[129:98]));
      cmp("resolved_mac",     64'(want.rmac),     64'(data[177:130]));
      cmp("tdata padding",    64'd0,              64'(data[183:178]));
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [175:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [183:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [47:0]  cfg_wdata;

  arp_cache_scoreboard sb = new();

  bit          src_steady;
  bit          sink_steady;
  bit          hold_req;
  int          hold_left;
  longint      cycles;
  logic [31:0] ip_pool [POOL_SIZE];

  arp_cache_and_responder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check every accepted result item
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_arp_result(out_tuser, out_tdata);
  end

  // Receiver: random stalls, steady stretches and one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= sink_steady || ($urandom_range(0, 99) >= 33);
    end
  end

  function automatic logic [47:0] rand_mac();
    return {16'($urandom()), $urandom()};
  endfunction

  function automatic logic [31:0] pool_ip();
    return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Received packet; the query field carries noise
  function automatic arp_item_t mk_packet(logic [10:0] len, logic [15:0] opc,
                                          logic [47:0] smac, logic [31:0] sip,
                                          logic [31:0] tip);
    arp_item_t it;
    it.op   = arp_pkg::OP_PACKET;
    it.len  = len;
    it.opc  = opc;
    it.smac = smac;
    it.sip  = sip;
    it.tip  = tip;
    it.qip  = $urandom();
    return it;
  endfunction

  // Resolve query; the packet fields carry noise
  function automatic arp_item_t mk_query(logic [31:0] qip);
    arp_item_t it;
    it = mk_packet(11'($urandom()), 16'($urandom()), rand_mac(), $urandom(), $urandom());
    it.op  = arp_pkg::OP_QUERY;
    it.qip = qip;
    return it;
  endfunction

  // Mostly well-formed traffic around a small address pool
  function automatic arp_item_t rand_item();
    arp_item_t   it;
    int unsigned r;
    logic [10:0] len;
    logic [15:0] opc;
    logic [31:0] sip;
    logic [31:0] tip;
    r = $urandom_range(0, 99);
    len = (r < 8) ? 11'($urandom_range(0, 27)) :
          (r < 12) ? arp_pkg::MIN_PACKET_LEN : 11'($urandom_range(28, 2047));
    r = $urandom_range(0, 99);
    opc = (r < 45) ? arp_pkg::ARP_OPC_REQUEST : (r < 80) ? 16'd2 : 16'($urandom());
    sip = ($urandom_range(0, 99) < 85) ? pool_ip() : $urandom();
    r = $urandom_range(0, 99);
    tip = (r < 50) ? sb.my_ip : (r < 70) ? pool_ip() : $urandom();
    if ($urandom_range(0, 99) < 40)
      it = mk_query(($urandom_range(0, 99) < 75) ? pool_ip() : $urandom());
    else
      it = mk_packet(len, opc, rand_mac(), sip, tip);
    return it;
  endfunction

  // Offer one item; called at a falling edge, returns at a falling edge
  task automatic send_item(arp_item_t it);
    while (!src_steady && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {5'd0, it.qip, it.tip, it.sip, it.smac, it.opc, it.len};
    do @(posedge clk); while (!in_tready);
    sb.accept_arp_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_station(logic [31:0] ip, logic [47:0] mac);
    write_reg(arp_pkg::CFG_LOCAL_IP, {16'd0, ip});
    write_reg(arp_pkg::CFG_LOCAL_MAC, mac);
    cfg_valid <= 1'b0;
  endtask

  // Drop the input, drain all results and let the block go idle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic new_pool();
    foreach (ip_pool[i]) ip_pool[i] = $urandom();
    ip_pool[0] = '0;
    ip_pool[1] = '1;
  endtask

  initial begin
    logic [31:0] st_ip;
    logic [47:0] st_mac;
    logic [31:0] ip_a;
    logic [31:0] ip_b;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = arp_pkg::OP_PACKET;
    cfg_valid  = 1'b0;
    cfg_index  = arp_pkg::CFG_LOCAL_IP;
    cfg_wdata  = '0;
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    hold_req    = 1'b0;
    hold_left   = 0;
    cycles      = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: drops, replies, opcodes, updates, hits, misses, slot wrap
    st_ip = 32'hC0A8_0001;
    ip_a  = 32'h0A00_0001;
    ip_b  = 32'h0A00_0002;
    set_station(st_ip, 48'h0200_0000_0001);
    send_item(mk_packet(11'd0, arp_pkg::ARP_OPC_REQUEST, rand_mac(), ip_a, st_ip));
    send_item(mk_packet(11'd27, arp_pkg::ARP_OPC_REQUEST, rand_mac(), ip_a, st_ip));
    send_item(mk_query(ip_a));
    send_item(mk_packet(arp_pkg::MIN_PACKET_LEN, arp_pkg::ARP_OPC_REQUEST, '1, ip_a, st_ip));
    send_item(mk_query(ip_a));
    send_item(mk_packet(11'd2047, 16'd2, '0, ip_a, st_ip));
    send_item(mk_query(ip_a));
    send_item(mk_packet(11'd60, arp_pkg::ARP_OPC_REQUEST, rand_mac(), ip_b, ~st_ip));
    send_item(mk_packet(11'd46, 16'd0, rand_mac(), '0, st_ip));
    send_item(mk_packet(11'd46, 16'hFFFF, rand_mac(), '1, st_ip));
    send_item(mk_query('0));
    send_item(mk_query('1));
    for (int i = 0; i < 6; i++)
      send_item(mk_packet(11'd28, arp_pkg::ARP_OPC_REQUEST, rand_mac(),
                          32'h0A00_0010 + i, st_ip));
    send_item(mk_query(ip_a));
    send_item(mk_query(ip_b));
    send_item(mk_query(32'h0A00_0015));
    drain();

    // Random phases under changing station addresses
    for (int p = 0; p < RAND_PHASES; p++) begin
      new_pool();
      case (p)
        0: begin
          st_ip  = '0;
          st_mac = '0;
        end
        1: begin
          st_ip  = '1;
          st_mac = '1;
        end
        3: begin
          st_ip  = ip_pool[2];
          st_mac = rand_mac();
        end
        default: begin
          st_ip  = $urandom();
          st_mac = rand_mac();
        end
      endcase
      set_station(st_ip, st_mac);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        src_steady  = (p == 2 && n < 200);
        sink_steady = (p == 2 && n < 200);
        if (p == 1 && n == 20) hold_req = 1'b1;
        send_item(rand_item());
      end
      src_steady  = 1'b0;
      sink_steady = 1'b0;
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/arp_pkg.sv
rtl/arp_cache.sv
rtl/arp_cache_and_responder.sv
tb/sv/arp_cache_and_responder_tb.sv
